/* rtl/aeop_pkg.sv */
`default_nettype none

package aeop_pkg;

	parameter int MAX_FRAMES_DEF = 1024;

	parameter int SMP_W     = 16;
	parameter int POWER_W   = 24;
	parameter int Q14_W     = 16;
	parameter int ADDR_W    = 5;
	parameter int DATA_W    = 32;
	parameter int SUM_SHIFT = 6;   // mean square scaled by 1/64 to land in Q0.24
	parameter int ACC_W     = 28;  // 9*avg + change + 5 fits below 2^28
	parameter int THR_W     = POWER_W + Q14_W;

	// floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT, exact for any 32-bit x
	parameter logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	parameter int          RECIP10_SHIFT = 35;
	parameter logic [ACC_W-1:0] EMA_ROUND = ACC_W'(5);

	parameter logic [Q14_W-1:0] HALF_Q14 = 16'd8192;

	parameter logic [1:0] MODE_NORMAL = 2'd0;
	parameter logic [1:0] MODE_HALF   = 2'd2;

	typedef enum logic [2:0] {
		REG_STEREO    = 3'd0,
		REG_MODE      = 3'd1,
		REG_THRESHOLD = 3'd2,
		REG_PULSE_MAX = 3'd3,
		REG_PULSE_MIN = 3'd4,
		REG_DECAY     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic              stereo;
		logic [1:0]        mode;
		logic [Q14_W-1:0]  thr;
		logic [Q14_W-1:0]  pmax;
		logic [Q14_W-1:0]  pmin;
		logic [Q14_W-1:0]  decay;
	} cfg_t;

	parameter cfg_t CFG_RESET = '{
		stereo: 1'b1,
		mode:   MODE_NORMAL,
		thr:    16'd4096,
		pmax:   16'd16384,
		pmin:   16'd0,
		decay:  16'd62259
	};

	typedef enum logic [2:0] {
		A_IDLE,
		A_DIV,
		A_EMA,
		A_AVG,
		A_THR,
		A_ONSET,
		A_DECAY,
		A_OUT
	} ana_state_t;

endpackage

`default_nettype wire

/* rtl/aeop_if.sv */
`default_nettype none

interface aeop_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [aeop_pkg::SMP_W-1:0]  left_sample;
	logic signed [aeop_pkg::SMP_W-1:0]  right_sample;
	logic                               block_end;

	modport source (output valid, left_sample, right_sample, block_end, input ready);
	modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface aeop_out_if;
	logic                        valid;
	logic                        ready;
	logic [aeop_pkg::Q14_W-1:0]  amplitude;

	modport source (output valid, amplitude, input ready);
	modport sink   (input valid, amplitude, output ready);
endinterface

`default_nettype wire

/* rtl/aeop_accum.sv */
`default_nettype none

module aeop_accum #(
	parameter int  MAX_FRAMES = aeop_pkg::MAX_FRAMES_DEF,
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1),
	localparam int SUM_W      = 31 + $clog2(MAX_FRAMES)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               take,
	input  wire logic signed [aeop_pkg::SMP_W-1:0]  left_sample,
	input  wire logic signed [aeop_pkg::SMP_W-1:0]  right_sample,
	input  wire logic                               block_end,
	input  wire logic                               stereo,
	output logic                                    blk_valid,
	output logic [SUM_W-1:0]                        blk_sum,
	output logic [CNT_W-1:0]                        blk_cnt
);
	import aeop_pkg::*;

	logic [CNT_W-1:0]         cnt_q;
	logic                     room;
	logic signed [SMP_W:0]    mix_sum;
	logic [SMP_W:0]           mix_adj;
	logic [SMP_W-1:0]         mono;

	logic                     v_s1, end_s1, use_s1;
	logic signed [SMP_W-1:0]  m_s1;
	logic [CNT_W-1:0]         cnt_s1;

	logic                     v_s2, end_s2, use_s2;
	logic [30:0]              sq_s2;
	logic [CNT_W-1:0]         cnt_s2;
	logic signed [31:0]       sq_full;

	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         addend;
	logic [SUM_W-1:0]         sum_next;

	assign room = cnt_q < CNT_W'(MAX_FRAMES);

	// downmix with truncation toward zero: bias negatives by one before halving
	assign mix_sum = (SMP_W+1)'(left_sample) + (SMP_W+1)'(right_sample);
	assign mix_adj = mix_sum + {{SMP_W{1'b0}}, mix_sum[SMP_W]};
	assign mono    = stereo ? mix_adj[SMP_W:1] : left_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (take) begin
				if (block_end) begin
					cnt_q <= '0;
				end else if (room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		end_s1 <= block_end;
		use_s1 <= room;
		m_s1   <= mono;
		cnt_s1 <= cnt_q + CNT_W'(room);
	end

	assign sq_full = 32'(m_s1) * 32'(m_s1);

	always_ff @(posedge clk) begin
		end_s2 <= end_s1;
		use_s2 <= use_s1;
		sq_s2  <= sq_full[30:0];
		cnt_s2 <= cnt_s1;
	end

	assign addend   = use_s2 ? SUM_W'(sq_s2) : '0;
	assign sum_next = sum_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			blk_valid <= 1'b0;
		end else begin
			blk_valid <= v_s2 && end_s2;
			if (v_s2) begin
				sum_q <= end_s2 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && end_s2) begin
			blk_sum <= sum_next;
			blk_cnt <= cnt_s2;
		end
	end

endmodule

`default_nettype wire

/* rtl/aeop_lane.sv */
`default_nettype none

module aeop_lane #(
	parameter int CNT_W = 11,
	parameter int K     = 1
) (
	input  wire logic [CNT_W+1:0]  part,
	input  wire logic [CNT_W-1:0]  dvs,
	output logic [CNT_W+1:0]       diff,
	output logic                   fits
);
	logic [CNT_W+1:0]  mult;
	logic [CNT_W+2:0]  wide;

	// trial subtraction of K times the divisor
	assign mult = {2'b00, dvs} * (CNT_W+2)'(K);
	assign wide = {1'b0, part} - {1'b0, mult};
	assign fits = !wide[CNT_W+2];
	assign diff = wide[CNT_W+1:0];

endmodule

`default_nettype wire

/* rtl/aeop_div.sv */
`default_nettype none

module aeop_div #(
	parameter int  MAX_FRAMES = aeop_pkg::MAX_FRAMES_DEF,
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1),
	localparam int SUM_W      = 31 + $clog2(MAX_FRAMES)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [SUM_W-1:0]              sum,
	input  wire logic [CNT_W-1:0]              cnt,
	output logic                               done,
	output logic [aeop_pkg::POWER_W-1:0]       quo
);
	import aeop_pkg::*;

	localparam int DW     = SUM_W - SUM_SHIFT;
	localparam int STEPS  = POWER_W / 2;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int LANES  = 3;

	logic [DW-1:0]       dvd;
	logic                sat;
	logic                run_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [CNT_W-1:0]    rem_q;
	logic [POWER_W-1:0]  low_q;
	logic [CNT_W+1:0]    part;
	logic [CNT_W+1:0]    diff [LANES];
	logic [LANES-1:0]    fits;
	logic [1:0]          digit;
	logic [CNT_W+1:0]    rem_sel;

	assign dvd = sum[SUM_W-1:SUM_SHIFT];
	// quotient would not fit in 24 bits: clamp
	assign sat = dvd >= DW'({cnt, {POWER_W{1'b0}}});

	assign part = {rem_q, low_q[POWER_W-1 -: 2]};

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		aeop_lane #(
			.CNT_W (CNT_W),
			.K     (k + 1)
		) u_lane (
			.part (part),
			.dvs  (dvs_q),
			.diff (diff[k]),
			.fits (fits[k])
		);
	end

	// merge: take the largest multiple that still fits
	always_comb begin
		digit   = 2'd0;
		rem_sel = part;
		if (fits[2]) begin
			digit   = 2'd3;
			rem_sel = diff[2];
		end else if (fits[1]) begin
			digit   = 2'd2;
			rem_sel = diff[1];
		end else if (fits[0]) begin
			digit   = 2'd1;
			rem_sel = diff[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				if (cnt == '0 || sat) begin
					done <= 1'b1;
				end else begin
					run_q  <= 1'b1;
					step_q <= STEP_W'(STEPS);
				end
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= cnt;
			rem_q <= dvd[POWER_W +: CNT_W];
			low_q <= dvd[POWER_W-1:0];
			if (cnt == '0) begin
				quo <= '0;
			end else if (sat) begin
				quo <= '1;
			end
		end else if (run_q) begin
			rem_q <= rem_sel[CNT_W-1:0];
			low_q <= {low_q[POWER_W-3:0], 2'b00};
			quo   <= {quo[POWER_W-3:0], digit};
		end
	end

endmodule

`default_nettype wire

/* rtl/aeop_analyse.sv */
`default_nettype none

module aeop_analyse #(
	parameter int  MAX_FRAMES = aeop_pkg::MAX_FRAMES_DEF,
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1),
	localparam int SUM_W      = 31 + $clog2(MAX_FRAMES)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire aeop_pkg::cfg_t            cfg,
	input  wire logic                      start,
	input  wire logic [SUM_W-1:0]          blk_sum,
	input  wire logic [CNT_W-1:0]          blk_cnt,
	output logic                           res_valid,
	output logic [aeop_pkg::Q14_W-1:0]     res_amp,
	input  wire logic                      res_ack
);
	import aeop_pkg::*;

	ana_state_t          state_q, state_d;
	logic                div_start;
	logic                div_done;
	logic [POWER_W-1:0]  div_quo;

	logic [POWER_W-1:0]  power_q, last_q, avg_q;
	logic [Q14_W-1:0]    pulse_q;
	logic [POWER_W-1:0]  diff_q;
	logic                rise_q;
	logic [ACC_W-1:0]    acc_q;
	logic [THR_W-1:0]    thr_q;
	logic [Q14_W-1:0]    dec_q;

	logic [POWER_W-1:0]  change;
	logic [59:0]         recip_prod;
	logic [THR_W-1:0]    thr_prod;
	logic [Q14_W-1:0]    psel_d;
	logic [31:0]         dec_prod;
	logic                onset;
	logic [Q14_W-1:0]    clamp_hi, clamp;

	aeop_div #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (blk_sum),
		.cnt    (blk_cnt),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			A_IDLE: begin
				if (start) begin
					state_d = (cfg.mode == MODE_NORMAL) ? A_DIV : A_OUT;
				end
			end
			A_DIV: begin
				if (div_done) begin
					state_d = A_EMA;
				end
			end
			A_EMA:   state_d = A_AVG;
			A_AVG:   state_d = A_THR;
			A_THR:   state_d = A_ONSET;
			A_ONSET: state_d = A_DECAY;
			A_DECAY: state_d = A_OUT;
			A_OUT: begin
				if (res_ack) begin
					state_d = A_IDLE;
				end
			end
			default: state_d = A_IDLE;
		endcase
	end

	always_comb begin
		div_start = (state_q == A_IDLE) && start && (cfg.mode == MODE_NORMAL);
		res_valid = (state_q == A_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			last_q  <= '0;
			avg_q   <= '0;
			pulse_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == A_AVG) begin
				avg_q <= recip_prod[RECIP10_SHIFT +: POWER_W];
			end
			if (state_q == A_DECAY) begin
				pulse_q <= clamp;
				last_q  <= power_q;
			end
		end
	end

	assign change     = rise_q ? diff_q : last_q - power_q;
	assign recip_prod = 60'(acc_q) * 60'(RECIP10);
	assign thr_prod   = THR_W'(avg_q) * THR_W'(cfg.thr);
	assign onset      = rise_q && (THR_W'({diff_q, 12'b0}) > thr_q);
	// an onset restarts the pulse at its ceiling before this block's decay
	assign psel_d     = onset ? cfg.pmax : pulse_q;
	assign dec_prod   = 32'(psel_d) * 32'(cfg.decay);
	assign clamp_hi   = (dec_q > cfg.pmax) ? cfg.pmax : dec_q;
	assign clamp      = (clamp_hi < cfg.pmin) ? cfg.pmin : clamp_hi;

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (start) begin
					res_amp <= (cfg.mode == MODE_HALF) ? HALF_Q14 : '0;
				end
			end
			A_DIV: begin
				if (div_done) begin
					power_q <= div_quo;
					rise_q  <= div_quo > last_q;
					diff_q  <= div_quo - last_q;
				end
			end
			A_EMA: begin
				acc_q <= ACC_W'({avg_q, 3'b000}) + ACC_W'(avg_q) + ACC_W'(change) + EMA_ROUND;
			end
			A_THR: begin
				thr_q <= thr_prod;
			end
			A_ONSET: begin
				dec_q <= 16'(dec_prod >> 16);
			end
			A_DECAY: begin
				res_amp <= clamp;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/audio_energy_onset_pulse.sv */
`default_nettype none

// Path: a block_end beat in normal mode passes the square stage, accumulate, a radix-4 divide,
// the EMA, average, threshold, onset and decay sequencer states and the output register; the
// forced modes go straight from accumulate to the output register.
// Throughput: one frame per cycle inside a block; a block_end beat holds the input off until
// its result enters the output register.
// Reset (arst_n low, asynchronous): state and pulse clear; registers take their defaults.
module audio_energy_onset_pulse #(
	parameter int MAX_FRAMES = aeop_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	aeop_in_if.sink                             frame,
	aeop_out_if.source                          pulse,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [aeop_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [aeop_pkg::DATA_W-1:0]    pwdata,
	output logic [aeop_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	import aeop_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W = 31 + $clog2(MAX_FRAMES);

	cfg_t              cfg_q;
	reg_idx_t          reg_idx;
	logic              cfg_wr;

	logic              take;
	logic              busy_q;
	logic              blk_valid;
	logic [SUM_W-1:0]  blk_sum;
	logic [CNT_W-1:0]  blk_cnt;
	logic              res_valid;
	logic [Q14_W-1:0]  res_amp;
	logic              res_ack;

	logic              out_v_q;
	logic [Q14_W-1:0]  amp_q;

	// ---------------------------------------------------------------------------------------
	// Register port: write on the access phase, zero wait states
	// ---------------------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_STEREO:    cfg_q.stereo <= pwdata[0];
				REG_MODE:      cfg_q.mode   <= pwdata[1:0];
				REG_THRESHOLD: cfg_q.thr    <= pwdata[Q14_W-1:0];
				REG_PULSE_MAX: cfg_q.pmax   <= pwdata[Q14_W-1:0];
				REG_PULSE_MIN: cfg_q.pmin   <= pwdata[Q14_W-1:0];
				REG_DECAY:     cfg_q.decay  <= pwdata[Q14_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back: unmapped offsets return zero
	always_comb begin
		case (reg_idx)
			REG_STEREO:    prdata = DATA_W'(cfg_q.stereo);
			REG_MODE:      prdata = DATA_W'(cfg_q.mode);
			REG_THRESHOLD: prdata = DATA_W'(cfg_q.thr);
			REG_PULSE_MAX: prdata = DATA_W'(cfg_q.pmax);
			REG_PULSE_MIN: prdata = DATA_W'(cfg_q.pmin);
			REG_DECAY:     prdata = DATA_W'(cfg_q.decay);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------------------------
	// Input side: frames stream in every cycle; a block_end beat closes the block and holds
	// the input off until its result has moved into the output register.
	// ---------------------------------------------------------------------------------------
	assign frame.ready = !busy_q;
	assign take        = frame.valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take && frame.block_end) begin
			busy_q <= 1'b1;
		end else if (res_ack) begin
			busy_q <= 1'b0;
		end
	end

	aeop_accum #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.left_sample  (frame.left_sample),
		.right_sample (frame.right_sample),
		.block_end    (frame.block_end),
		.stereo       (cfg_q.stereo),
		.blk_valid    (blk_valid),
		.blk_sum      (blk_sum),
		.blk_cnt      (blk_cnt)
	);

	// Block analysis (normal mode): divide for power, then change average, onset test, pulse decay
	aeop_analyse #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_analyse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (blk_valid),
		.blk_sum   (blk_sum),
		.blk_cnt   (blk_cnt),
		.res_valid (res_valid),
		.res_amp   (res_amp),
		.res_ack   (res_ack)
	);

	// ---------------------------------------------------------------------------------------
	// Output register: load when empty or being drained this cycle, otherwise hold
	// ---------------------------------------------------------------------------------------
	assign res_ack = res_valid && (!out_v_q || pulse.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ack) begin
			out_v_q <= 1'b1;
		end else if (pulse.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			amp_q <= res_amp;
		end
	end

	assign pulse.valid     = out_v_q;
	assign pulse.amplitude = amp_q;

endmodule

`default_nettype wire
